// ----- hw/rtl/npc_pkg.sv -----
package npc_pkg;

  localparam int DEF_ENTRIES = 256;
  localparam int IDX_W       = 8;
  localparam int CH_W        = 8;
  localparam int SQ_W        = 2 * CH_W;
  // three squared channel differences, at most 195075
  localparam int DIST_W      = 18;
  localparam int CS_W        = 4;
  localparam int LIMIT_W     = IDX_W + 1;

  localparam logic [CS_W-1:0]   SEARCH_BITS_RESET = 4'd8;
  localparam logic [CS_W-1:0]   SEARCH_BITS_MIN   = 4'd1;
  localparam logic [CS_W-1:0]   SEARCH_BITS_MAX   = 4'd8;
  localparam logic [DIST_W-1:0] DIST_INIT         = '1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [DIST_W-1:0] best;
    logic [IDX_W-1:0]  best_idx;
  } npc_item_t;

  // built-in palette: index = r3 g3 b2
  function automatic logic [3*CH_W-1:0] default_entry(input logic [IDX_W-1:0] i);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    r = {i[7:5], 5'd0};
    g = {i[4:2], 5'd0};
    b = {i[1:0], 6'd0};
    return {r, g, b};
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    logic [SQ_W-1:0] dw;
    d  = (a > b) ? (a - b) : (b - a);
    dw = SQ_W'(d);
    return SQ_W'(dw * dw);
  endfunction

endpackage

// ----- hw/rtl/npc_cell.sv -----
module npc_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [npc_pkg::LIMIT_W-1:0] limit,
  input  npc_pkg::npc_item_t      in_item,
  output npc_pkg::npc_item_t      out_item
);
  import npc_pkg::*;

  localparam logic [LIMIT_W-1:0] CELL_POS = LIMIT_W'(CELL_INDEX);

  logic [3*CH_W-1:0] entry;
  npc_item_t         a_item;
  logic              a_use;
  logic [SQ_W-1:0]   a_sq_r;
  logic [SQ_W-1:0]   a_sq_g;
  logic [SQ_W-1:0]   a_sq_b;
  logic [DIST_W-1:0] sum_sq;
  npc_item_t         b_next;

  // palette entry held by this cell, updated by a write as it passes
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= default_entry(CELL_POS[IDX_W-1:0]);
    end else if (advance && in_item.valid && in_item.wr &&
                 in_item.idx == CELL_POS[IDX_W-1:0]) begin
      entry <= {in_item.red, in_item.green, in_item.blue};
    end
  end

  // first half: channel differences squared
  always_ff @(posedge clk) begin
    if (rst) begin
      a_item <= '0;
      a_use  <= 1'b0;
    end else if (advance) begin
      a_item <= in_item;
      a_use  <= in_item.valid && !in_item.wr && (CELL_POS < limit);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_sq_r <= sq_diff(entry[3*CH_W-1:2*CH_W], in_item.red);
      a_sq_g <= sq_diff(entry[2*CH_W-1:CH_W], in_item.green);
      a_sq_b <= sq_diff(entry[CH_W-1:0], in_item.blue);
    end
  end

  // second half: sum and keep the smaller, strict compare keeps the lower index
  always_comb begin
    sum_sq = DIST_W'(a_sq_r) + DIST_W'(a_sq_g) + DIST_W'(a_sq_b);
    b_next = a_item;
    if (a_use && sum_sq < a_item.best) begin
      b_next.best     = sum_sq;
      b_next.best_idx = CELL_POS[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_item <= '0;
    end else if (advance) begin
      out_item <= b_next;
    end
  end

endmodule

// ----- hw/rtl/nearest_palette_color.sv -----
// Nearest palette color quantizer, squared Euclidean distance in RGB.
// Request channel (req_valid/req_ready): req_type 0 carries a pixel in
// red/green/blue, req_type 1 writes red/green/blue into palette entry
// entry_index; a write gives no result and an index past the palette is dropped.
// Result channel (res_valid/res_ready), one per pixel, in order, lowest index on
// a tie: color_index of the closest of the first 2^search_bits (clamped 1..8).
// Config channel (cfg_valid/cfg_ready): cfg_data loads search_bits; write it
// only when no transaction is in flight. cfg_ready is always high.
// Each palette entry lives in its own cell of a chain; every cell has two
// register stages; a pixel passes through every cell and then the output
// register to the result port. Unless held, one transaction is taken per cycle.
// The whole chain moves together; while a result waits with res_ready low the
// chain holds and req_ready is low. The output register lets a new request
// in during the cycle the waiting result is taken.
// Reset clears the chain and output, loads the r3 g3 b2 default palette into
// the cells and sets search_bits to 8.
module nearest_palette_color #(
  parameter int PALETTE_ENTRIES = npc_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        req_type,
  input  logic [npc_pkg::IDX_W-1:0]   entry_index,
  input  logic [npc_pkg::CH_W-1:0]    red,
  input  logic [npc_pkg::CH_W-1:0]    green,
  input  logic [npc_pkg::CH_W-1:0]    blue,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [npc_pkg::IDX_W-1:0]   color_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [npc_pkg::CS_W-1:0]    cfg_data
);
  import npc_pkg::*;

  logic [CS_W-1:0]    search_bits;
  logic [CS_W-1:0]    cs_eff;
  logic [LIMIT_W-1:0] limit;
  logic               advance;
  npc_item_t          link [PALETTE_ENTRIES+1];
  npc_item_t          tail;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_bits <= SEARCH_BITS_RESET;
    end else if (cfg_valid) begin
      search_bits <= cfg_data;
    end
  end

  always_comb begin
    cs_eff = search_bits;
    if (search_bits < SEARCH_BITS_MIN) cs_eff = SEARCH_BITS_MIN;
    if (search_bits > SEARCH_BITS_MAX) cs_eff = SEARCH_BITS_MAX;
    limit = LIMIT_W'(1) << cs_eff;
  end

  assign advance   = !res_valid || res_ready;
  assign req_ready = advance;

  always_comb begin
    link[0].valid    = req_valid;
    link[0].wr       = (req_type == REQ_WRITE);
    link[0].idx      = entry_index;
    link[0].red      = red;
    link[0].green    = green;
    link[0].blue     = blue;
    link[0].best     = DIST_INIT;
    link[0].best_idx = '0;
  end

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npc_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .limit   (limit),
      .in_item (link[i]),
      .out_item(link[i+1])
    );
  end

  assign tail = link[PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= tail.valid && !tail.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color_index <= tail.best_idx;
    end
  end

endmodule

// ----- hw/rtl/npc_checker.sv -----
module npc_protocol_props (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] color_index,
  input logic       cfg_ready
);

  // a stalled result holds its index
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(color_index))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !req_ready)
    else $error("request taken while output stalled");

  // empty or draining output lets requests in
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> req_ready && cfg_ready)
    else $error("request blocked with free output");

endmodule

bind nearest_palette_color npc_protocol_props u_npc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .color_index(color_index),
  .cfg_ready  (cfg_ready)
);
